@@ src/sha_pkg.sv @@
`default_nettype none
package sha_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_FOLD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       wr_byte;
        logic [7:0] wr_data;
        logic       wr_len;
        logic       start;
        logic       step;
        logic       fold;
        logic       snap_len;
        logic       init;
        logic       out_load;
        logic [2:0] out_idx;
        logic       out_last;
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic [5:0] round;
    } t_status;

    localparam int unsigned DIGEST_WORDS_256 = 8;
    localparam int unsigned DIGEST_WORDS_224 = 7;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] IV256 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] IV224 [8] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

@@ src/sha_datapath.sv @@
`default_nettype none
module sha_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_mode,
    input  wire logic             i_cfg_we,
    input  wire sha_pkg::t_cmd    i_cmd,
    output sha_pkg::t_status      o_status,
    output sha_pkg::t_out_item    o_out
);
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_fill;
    logic [5:0]  r_round;
    logic [54:0] r_blocks;
    logic [63:0] r_bits;
    sha_pkg::t_out_item r_out;

    logic [31:0] w_t, s0, s1, t1, t2, e, a;
    logic [31:0] w_new;
    logic [7:0]  wr_val;

    always_comb begin
        w_t = r_w[0];
        s0 = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        e = r_v[4];
        a = r_v[0];
        t1 = r_v[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
           + ((e & r_v[5]) ^ (~e & r_v[6])) + sha_pkg::ROUND_K[r_round] + w_t;
        t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
           + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
        wr_val = i_cmd.wr_len ? r_bits[63 - 8 * (r_fill[2:0]) -: 8] : i_cmd.wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte || i_cmd.wr_len) begin
            r_w[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= wr_val;
        end
        if (i_cmd.start) begin
            for (int k = 0; k < 8; k++) begin
                r_v[k] <= r_h[k];
            end
        end else if (i_cmd.step) begin
            for (int k = 0; k < 15; k++) begin
                r_w[k] <= r_w[k+1];
            end
            r_w[15] <= w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_cmd.out_load) begin
            r_out.digest_word <= r_h[i_cmd.out_idx];
            r_out.word_index  <= i_cmd.out_idx;
            r_out.last_word   <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) r_h[k] <= sha_pkg::IV256[k];
            r_fill   <= '0;
            r_round  <= '0;
            r_blocks <= '0;
            r_bits   <= '0;
        end else if (i_cfg_we || i_cmd.init) begin
            for (int k = 0; k < 8; k++) begin
                r_h[k] <= i_mode ? sha_pkg::IV224[k] : sha_pkg::IV256[k];
            end
            r_fill   <= '0;
            r_blocks <= '0;
        end else begin
            if (i_cmd.snap_len) begin
                r_bits <= {r_blocks, r_fill, 3'b000};
            end
            if (i_cmd.wr_byte || i_cmd.wr_len) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.start) begin
                r_round <= '0;
            end else if (i_cmd.step) begin
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.fold) begin
                for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
                r_blocks <= r_blocks + 55'd1;
            end
        end
    end

    assign o_status.fill  = r_fill;
    assign o_status.round = r_round;
    assign o_out = r_out;
endmodule
`default_nettype wire

@@ src/sha_control.sv @@
`default_nettype none
module sha_control (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_mode,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  sha_pkg::t_in_item     i_item,
    output logic                  o_valid,
    input  wire logic             i_stall,
    input  sha_pkg::t_status      i_status,
    output sha_pkg::t_cmd         o_cmd
);
    sha_pkg::t_state r_state, n_state;
    logic r_fin, n_fin;
    logic r_final, n_final;
    logic r_ovalid, n_ovalid;
    logic [2:0] r_idx, n_idx;
    logic [2:0] last_idx;

    assign last_idx = i_mode ? 3'(sha_pkg::DIGEST_WORDS_224 - 1)
                             : 3'(sha_pkg::DIGEST_WORDS_256 - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha_pkg::ST_IDLE;
            r_fin    <= 1'b0;
            r_final  <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_fin    <= n_fin;
            r_final  <= n_final;
            r_ovalid <= n_ovalid;
            r_idx    <= n_idx;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_fin    = r_fin;
        n_final  = r_final;
        n_ovalid = r_ovalid;
        n_idx    = r_idx;
        o_cmd    = '0;
        o_stall  = 1'b1;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            sha_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (!i_item.cmd) begin
                        o_cmd.wr_byte = 1'b1;
                        o_cmd.wr_data = i_item.data_byte;
                        n_fin = 1'b0;
                    end else begin
                        o_cmd.snap_len = 1'b1;
                        o_cmd.wr_byte  = 1'b1;
                        o_cmd.wr_data  = sha_pkg::PAD_BYTE;
                        n_fin = 1'b1;
                    end
                    if (i_status.fill == 6'd63) begin
                        n_state = sha_pkg::ST_COMP;
                        o_cmd.start = 1'b1;
                    end else if (i_item.cmd) begin
                        n_state = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_PAD: begin
                if (i_status.fill == 6'd56) begin
                    n_state = sha_pkg::ST_LEN;
                end else begin
                    o_cmd.wr_byte = 1'b1;
                    o_cmd.wr_data = 8'h00;
                    if (i_status.fill == 6'd63) begin
                        n_state = sha_pkg::ST_COMP;
                        o_cmd.start = 1'b1;
                    end
                end
            end
            sha_pkg::ST_LEN: begin
                o_cmd.wr_len = 1'b1;
                if (i_status.fill == 6'd63) begin
                    n_state = sha_pkg::ST_COMP;
                    o_cmd.start = 1'b1;
                    n_fin = 1'b0;
                    n_final = 1'b1;
                end
            end
            sha_pkg::ST_COMP: begin
                o_cmd.step = 1'b1;
                if (i_status.round == 6'd63) begin
                    n_state = sha_pkg::ST_FOLD;
                end
            end
            sha_pkg::ST_FOLD: begin
                o_cmd.fold = 1'b1;
                n_idx = '0;
                if (r_final) begin
                    n_state = sha_pkg::ST_EMIT;
                    n_final = 1'b0;
                end else if (r_fin) begin
                    n_state = sha_pkg::ST_PAD;
                end else begin
                    n_state = sha_pkg::ST_IDLE;
                end
            end
            sha_pkg::ST_EMIT: begin
                if (!r_ovalid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_idx  = r_idx;
                    o_cmd.out_last = (r_idx == last_idx);
                    n_ovalid = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == last_idx) begin
                        o_cmd.init = 1'b1;
                        n_state = sha_pkg::ST_IDLE;
                        n_idx = '0;
                    end
                end
            end
            default: n_state = sha_pkg::ST_IDLE;
        endcase
    end

    assign o_valid = r_ovalid;

`ifndef NO_ASSERTIONS
    a_emit_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha_pkg::ST_EMIT) |-> o_stall)
        else $error("input taken during digest output");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_ovalid || !i_stall))
        else $error("output overwritten while stalled");
    a_init_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.init |-> o_cmd.out_last)
        else $error("restart without last word");
`endif
endmodule
`default_nettype wire

@@ src/sha256_224_hasher.sv @@
`default_nettype none
// channel  | handshake              | payload
// in       | i_valid / o_stall      | i_item (cmd, data_byte)
// out      | o_valid / i_stall      | o_item (digest_word, word_index, last_word)
// cfg      | i_cfg_we               | i_cfg_data (digest_mode)
// Data bytes are taken while the control is idle; the byte that fills a block
// starts the 64 rounds of the shared round unit, and input stalls until the block is folded.
// Finish pads one byte a cycle, compresses one or two blocks, then emits
// 7 or 8 words at one per cycle while the output is not stalled.
// Reset is synchronous, active low; it loads the SHA-256 initial values.
module sha256_224_hasher (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_data,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  sha_pkg::t_in_item     i_item,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output sha_pkg::t_out_item    o_item
);
    logic r_mode;
    sha_pkg::t_cmd    cmd;
    sha_pkg::t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    sha_control u_ctl (
        .i_clk, .i_rst_n, .i_mode(r_mode), .i_valid, .o_stall, .i_item,
        .o_valid, .i_stall, .i_status(status), .o_cmd(cmd));

    sha_datapath u_dp (
        .i_clk, .i_rst_n, .i_mode(i_cfg_we ? i_cfg_data : r_mode), .i_cfg_we,
        .i_cmd(cmd), .o_status(status), .o_out(o_item));
endmodule
`default_nettype wire

@@ tb/sv/sha_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module sha_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_data,
    input  wire logic           i_valid,
    input  wire logic           i_stall_in,
    input  sha_pkg::t_in_item   i_item,
    input  wire logic           i_valid_out,
    input  wire logic           i_stall,
    input  sha_pkg::t_out_item  i_out,
    output int                  o_errors,
    output int                  o_pending
);
    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam logic [31:0] H256 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] H224 [8] = '{
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};

    logic [31:0] hash_words [8];
    logic [7:0]  msg_block [64];
    logic [5:0]  fill;
    logic [54:0] blocks;
    logic        mode_224;
    sha_pkg::t_out_item digest_q [$];
    int          errors;

    assign o_errors  = errors;
    assign o_pending = digest_q.size();

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_words[i] = mode_224 ? H224[i] : H256[i];
        fill = 0;
        blocks = 0;
    endtask

    task automatic fold_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++) begin
            s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int i = 0; i < 8; i++) v[i] = hash_words[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_words[i] += v[i];
        blocks++;
    endtask

    task automatic append_byte(logic [7:0] b);
        msg_block[fill] = b;
        if (fill == 6'd63) begin
            fold_block();
            fill = 0;
        end else begin
            fill++;
        end
    endtask

    task automatic predict_digest(sha_pkg::t_in_item it);
        logic [63:0] bits;
        sha_pkg::t_out_item r;
        int          n;
        if (!it.cmd) begin
            append_byte(it.data_byte);
            return;
        end
        bits = {blocks, 9'd0} | {55'd0, fill, 3'd0};
        append_byte(8'h80);
        while (fill != 6'd56) append_byte(8'h00);
        for (int k = 0; k < 8; k++) msg_block[56 + k] = bits[63 - 8*k -: 8];
        fold_block();
        n = mode_224 ? 7 : 8;
        for (int k = 0; k < n; k++) begin
            r.digest_word = hash_words[k];
            r.word_index  = 3'(k);
            r.last_word   = (k == n - 1);
            digest_q.push_back(r);
        end
        restart_hash();
    endtask

    always @(posedge i_clk) begin
        sha_pkg::t_out_item exp_w;
        if (!i_rst_n) begin
            mode_224 = 0;
            restart_hash();
            digest_q.delete();
            errors = 0;
        end else begin
            if (i_cfg_we) begin
                mode_224 = i_cfg_data;
                restart_hash();
            end
            if (i_valid && !i_stall_in) predict_digest(i_item);
            if (i_valid_out && !i_stall) begin
                if (digest_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, actual %h", $time, i_out);
                end else begin
                    exp_w = digest_q.pop_front();
                    if (i_out !== exp_w) begin
                        errors++;
                        $display("%0t: mismatch expected %h/%0d/%0d actual %h/%0d/%0d",
                            $time, exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                            i_out.digest_word, i_out.word_index, i_out.last_word);
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_cfg_we = 0;
    logic      i_cfg_data = 0;
    logic      i_valid = 0;
    logic      o_stall;
    sha_pkg::t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_stall = 0;
    sha_pkg::t_out_item o_item;
    int        errors, pending;
    int        send_idle = 0, recv_idle = 0;
    int        hold_off = 0;
    int        quiet = 0;
    int        n_items = 0, n_msgs = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    sha256_224_hasher i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item));

    sha_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .i_stall_in(o_stall), .i_item(i_item),
        .i_valid_out(o_valid), .i_stall(i_stall), .i_out(o_item),
        .o_errors(errors), .o_pending(pending));

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("timeout");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send(logic c, logic [7:0] b);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_item <= '{cmd: c, data_byte: b};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_items++;
        if (c) n_msgs++;
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic set_mode(logic m);
        drain();
        i_cfg_we <= 1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic random_msg(int len);
        for (int i = 0; i < len; i++) send(1'b0, 8'($urandom));
        send(1'b1, 8'($urandom));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send(1'b1, 8'hff);
        send(1'b0, 8'h00); send(1'b0, 8'hff); send(1'b1, 8'h00);
        send(1'b0, 8'h61); send(1'b0, 8'h62); send(1'b0, 8'h63); send(1'b1, 8'h00);
        set_mode(1);
        send(1'b1, 8'h00);
        send(1'b0, 8'h61); send(1'b0, 8'h62); send(1'b0, 8'h63); send(1'b1, 8'h00);
        send(1'b0, 8'h55); send(1'b0, 8'haa);
        set_mode(0);
        send(1'b1, 8'h00);
        set_mode(0);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 16 : (phase == 1) ? 49 : 0;
            recv_idle = (phase == 0) ? 49 : (phase == 1) ? 16 : 0;
            if (phase == 2) hold_off = 400;
            while (n_items < 30 + 130 * (phase + 1)) begin
                case ($urandom_range(9))
                    0: random_msg(55 + $urandom_range(1));
                    1: random_msg(63 + $urandom_range(2));
                    2: send(1'b0, 8'($urandom));
                    default: random_msg($urandom_range(12));
                endcase
                if ($urandom_range(7) == 0) drain();
            end
            set_mode(phase[0] ? 1'b0 : 1'b1);
        end
        random_msg(0);
        set_mode(1);
        random_msg(3);
        drain();
        $display("Sent %0d items in %0d messages under both digest modes,", n_items, n_msgs);
        $display("with block boundaries, empty messages and stalls on both sides.");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
src/sha_pkg.sv
src/sha_datapath.sv
src/sha_control.sv
src/sha256_224_hasher.sv
tb/sv/sha_checker.sv
tb/sv/testbench.sv
